[rtl/npmt_pkg.sv]
// ----------------------------------------------------------------------------
// npmt_pkg: shared definitions for the neighborhood pattern match table
// Holds the table geometry, the command codes, the controller states, the
// memory request bundle and the pattern cover test.
// ----------------------------------------------------------------------------
package npmt_pkg;

  // Number of tasks kept per bitmap entry (1 to 16).
  localparam int TASKS = 4;

  // Field widths of one input item.
  localparam int NEIGH_W     = 9;
  localparam int TASK_FLD_W  = 4;
  localparam int TASK_IDX_W  = 2;

  // Bitmap geometry: one entry for every exact 3x3 neighborhood.
  localparam int DEPTH  = 1 << NEIGH_W;
  localparam int ADDR_W = NEIGH_W;
  localparam int CNT_W  = ADDR_W + 1;

  // Stream widths.
  localparam int IN_FLD_W  = 3 * NEIGH_W + TASK_FLD_W + TASK_IDX_W;
  localparam int IN_DATA_W = ((IN_FLD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8;

  // Command codes carried in tuser.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD
  } state_t;

  // One cycle of bitmap traffic: a read port and a write port.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [TASKS-1:0]  wr_data;
  } mem_req_t;

  // True when the neighborhood agrees with the pattern on every cared bit.
  function automatic logic covers(input logic [NEIGH_W-1:0] neigh,
                                  input logic [NEIGH_W-1:0] value,
                                  input logic [NEIGH_W-1:0] care);
    covers = (((neigh ^ value) & care) == '0);
  endfunction

endpackage

[rtl/npmt_bitmap.sv]
// ----------------------------------------------------------------------------
// npmt_bitmap: match bitmap storage
// One synchronous memory of DEPTH entries, TASKS bits each, with one write
// port and one read port whose data is registered and held between reads.
// ----------------------------------------------------------------------------
module npmt_bitmap
  import npmt_pkg::*;
(
  input  logic             clk,
  input  mem_req_t         req,
  output logic [TASKS-1:0] rd_data
);

  logic [TASKS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port; the output holds its value until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

[rtl/neighborhood_pattern_match_table.sv]
// ----------------------------------------------------------------------------
// neighborhood_pattern_match_table: 3x3 hit-or-miss pattern table
// A load item marks every neighborhood its pattern covers for each of its
// tasks in a 512-entry bitmap; a query item looks up one neighborhood and
// returns hit for the chosen task.
//
//   Channel  Dir  tdata fields (low bit up)                        tuser
//   s_*      in   pattern_value, pattern_care, pattern_tasks,      command
//                 neighbor_bits, task_index, zero fill to 40 bits
//   m_*      out  hit, zero fill to 8 bits                         -
//
// A query passes the bitmap read register and then the output register;
// queries are accepted every cycle while the table is idle and the read
// stage can move on, and the hit is offered from the output register.
// A load runs a read-modify-write sweep over all 512
// entries, read and write one entry apart, and gives no result.
// After reset a clearing pass writes zero to all 512 entries with s_tready
// low. A stalled result holds one query in the read stage; outside the
// sweeps, s_tready falls only when that stage cannot move on.
// ----------------------------------------------------------------------------
module neighborhood_pattern_match_table
  import npmt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pattern_value[8:0], pattern_care[17:9], pattern_tasks[21:18],
  // neighbor_bits[30:22], task_index[32:31], zero [39:33]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // command[0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // hit[0], zero [7:1]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int VAL_LO  = 0;
  localparam int CARE_LO = VAL_LO + NEIGH_W;
  localparam int TSK_LO  = CARE_LO + NEIGH_W;
  localparam int NB_LO   = TSK_LO + TASK_FLD_W;
  localparam int TI_LO   = NB_LO + NEIGH_W;
  localparam logic [CNT_W-1:0] CNT_LAST_ADDR = CNT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_END       = CNT_W'(DEPTH);

  // Unpacked input fields.
  logic [NEIGH_W-1:0]    in_value;
  logic [NEIGH_W-1:0]    in_care;
  logic [TASK_FLD_W-1:0] in_tasks;
  logic [NEIGH_W-1:0]    in_neigh;
  logic [TASK_IDX_W-1:0] in_task_idx;

  assign in_value    = s_tdata[VAL_LO  +: NEIGH_W];
  assign in_care     = s_tdata[CARE_LO +: NEIGH_W];
  assign in_tasks    = s_tdata[TSK_LO  +: TASK_FLD_W];
  assign in_neigh    = s_tdata[NB_LO   +: NEIGH_W];
  assign in_task_idx = s_tdata[TI_LO   +: TASK_IDX_W];

  // Controller and pipeline registers.
  state_t                state, state_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [NEIGH_W-1:0]    ld_value;
  logic [NEIGH_W-1:0]    ld_care;
  logic [TASKS-1:0]      ld_tasks;
  logic                  q_pend;
  logic [TASK_IDX_W-1:0] q_task;
  logic                  out_valid;
  logic                  out_hit;

  logic                  s_acc;
  logic                  q_acc;
  logic                  ld_acc;
  logic                  adv;
  logic                  hit_calc;
  logic [TASKS-1:0]      acc_tasks;
  logic [ADDR_W-1:0]     sweep_wr_addr;
  mem_req_t              req;
  logic [TASKS-1:0]      rd_data;

  // The read stage moves to the output register when that register is free.
  assign adv      = q_pend && (!out_valid || m_tready);
  assign s_tready = (state == ST_IDLE) && (!q_pend || adv);
  assign s_acc    = s_tvalid && s_tready;
  assign q_acc    = s_acc && (s_tuser == CMD_QUERY);
  assign ld_acc   = s_acc && (s_tuser == CMD_LOAD);

  // Task bits beyond the table width are dropped.
  always_comb begin
    acc_tasks = '0;
    for (int i = 0; i < TASKS; i++) begin
      if (i < TASK_FLD_W) begin
        acc_tasks[i] = in_tasks[i];
      end
    end
  end

  assign sweep_wr_addr = ADDR_W'(cnt - CNT_W'(1));

  // Next state, sweep counter and bitmap traffic.
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    req.rd_en   = 1'b0;
    req.rd_addr = in_neigh;
    req.wr_en   = 1'b0;
    req.wr_addr = cnt[ADDR_W-1:0];
    req.wr_data = '0;
    unique case (state)
      ST_CLEAR: begin
        req.wr_en = 1'b1;
        if (cnt == CNT_LAST_ADDR) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        req.rd_en = q_acc;
        if (ld_acc) begin
          state_next = ST_LOAD;
          cnt_next   = '0;
        end
      end
      ST_LOAD: begin
        // Read entry cnt while the entry read last cycle is written back.
        req.rd_en   = (cnt != CNT_END);
        req.rd_addr = cnt[ADDR_W-1:0];
        req.wr_addr = sweep_wr_addr;
        req.wr_data = rd_data | ld_tasks;
        req.wr_en   = (cnt != '0) && (ld_tasks != '0)
                      && covers(sweep_wr_addr, ld_value, ld_care);
        if (cnt == CNT_END) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Load fields captured for the sweep.
  always_ff @(posedge clk) begin
    if (ld_acc) begin
      ld_value <= in_value;
      ld_care  <= in_care;
      ld_tasks <= acc_tasks;
    end
  end

  // Query read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_pend <= 1'b0;
    end else if (q_acc) begin
      q_pend <= 1'b1;
    end else if (adv) begin
      q_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_acc) begin
      q_task <= in_task_idx;
    end
  end

  // Pick the task bit; an index beyond the table answers no hit.
  always_comb begin
    hit_calc = 1'b0;
    for (int i = 0; i < TASKS; i++) begin
      if (int'(q_task) == i) begin
        hit_calc = rd_data[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit <= hit_calc;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_DATA_W-1)'(0), out_hit};

  npmt_bitmap u_bitmap (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  // The sweep never reads and writes the same entry in one cycle.
  a_no_rw_same: assert property (@(posedge clk) disable iff (rst)
    !(req.rd_en && req.wr_en && (req.rd_addr == req.wr_addr)))
    else $error("bitmap read and write hit the same entry");

  // An accepted query occupies the read stage in the next cycle.
  a_query_pend: assert property (@(posedge clk) disable iff (rst)
    q_acc |=> q_pend)
    else $error("accepted query lost before the read stage");

  // No query is in flight while the bitmap is being cleared or loaded.
  a_sweep_quiet: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !q_pend)
    else $error("query in flight during a sweep");

  // A result stalled at the output keeps the read stage waiting.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (q_pend && out_valid && !m_tready) |=> q_pend)
    else $error("read stage dropped a query under stall");
`endif

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for neighborhood_pattern_match_table
// Pattern loads and neighborhood queries are streamed into the table.
// A local model of the 512-entry task bitmap predicts each query's hit
// bit, and every returned item is checked against the oldest prediction.
// Both stream sides idle and stall in random bursts, except near the end.
// ----------------------------------------------------------------------------
module tb
  import npmt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // One input item, with every field kept whether the command uses it or not.
  typedef struct {
    cmd_t                  cmd;
    logic [NEIGH_W-1:0]    value;
    logic [NEIGH_W-1:0]    care;
    logic [TASK_FLD_W-1:0] tasks;
    logic [NEIGH_W-1:0]    neigh;
    logic [TASK_IDX_W-1:0] tidx;
  } table_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = CMD_LOAD;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  neighborhood_pattern_match_table uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Model of the table and the predicted hit bits in order.
  logic [TASKS-1:0] task_marks [DEPTH];
  logic             expected_hits [$];
  table_item_t      pending_items [$];
  table_item_t      cur_item;

  int items_total    = 0;
  int items_accepted = 0;
  int loads_applied  = 0;
  int queries_sent   = 0;
  int results_seen   = 0;
  int hits_seen      = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int cycle_limit    = 2000000;
  int src_gap        = 0;
  int src_mode       = 1;
  int sink_stall     = 0;
  int sink_mode      = 1;

  initial begin
    forever #4 clk = ~clk;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR t=%0t result %0d: %s got %0d expected %0d",
             $realtime, results_seen, what, got, want);
    error_count++;
  endtask

  // Applies one accepted item to the model: a load marks every covered
  // neighborhood for its tasks, a query predicts its hit bit.
  task automatic update_task_marks(input table_item_t it);
    logic [TASKS-1:0]   task_set;
    logic [NEIGH_W-1:0] n_bits;
    if (it.cmd == CMD_LOAD) begin
      task_set = TASKS'(it.tasks);
      for (int n = 0; n < DEPTH; n++) begin
        n_bits = NEIGH_W'(n);
        if ((n_bits & it.care) == (it.value & it.care)) begin
          task_marks[n] = task_marks[n] | task_set;
        end
      end
      loads_applied++;
    end else begin
      if (int'(it.tidx) < TASKS) begin
        expected_hits.push_back(task_marks[it.neigh][it.tidx]);
      end else begin
        expected_hits.push_back(1'b0);
      end
      queries_sent++;
    end
  endtask

  // Loads carry random values in the query-only fields.
  task automatic add_load(input logic [NEIGH_W-1:0] value, input logic [NEIGH_W-1:0] care,
                          input logic [TASK_FLD_W-1:0] tasks);
    table_item_t it;
    it.cmd   = CMD_LOAD;
    it.value = value;
    it.care  = care;
    it.tasks = tasks;
    it.neigh = NEIGH_W'($urandom);
    it.tidx  = TASK_IDX_W'($urandom);
    pending_items.push_back(it);
  endtask

  // Queries carry random values in the load-only fields.
  task automatic add_query(input logic [NEIGH_W-1:0] neigh,
                           input logic [TASK_IDX_W-1:0] tidx);
    table_item_t it;
    it.cmd   = CMD_QUERY;
    it.value = NEIGH_W'($urandom);
    it.care  = NEIGH_W'($urandom);
    it.tasks = TASK_FLD_W'($urandom);
    it.neigh = neigh;
    it.tidx  = tidx;
    pending_items.push_back(it);
  endtask

  // Source side: presents pending items and idles in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= CMD_LOAD;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        update_task_marks(cur_item);
        items_accepted++;
        if (items_accepted % 40 == 0) begin
          src_mode = $urandom_range(0, 3);
        end
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          if (pending_items.size() > 60 && src_mode != 0 &&
              $urandom_range(0, 15) < src_mode) begin
            src_gap = $urandom_range(1, 19) - 1;
            s_tvalid <= 1'b0;
          end else begin
            cur_item = pending_items.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {{(IN_DATA_W - IN_FLD_W){1'b0}}, cur_item.tidx, cur_item.neigh,
                         cur_item.tasks, cur_item.care, cur_item.value};
            s_tuser  <= cur_item.cmd;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: checks each accepted item and stalls in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected result, hit", int'(m_tdata[0]), 0);
        end else begin
          if (m_tdata[0] != expected_hits[0]) begin
            report_mismatch("hit", int'(m_tdata[0]), int'(expected_hits[0]));
          end
          if (m_tdata[OUT_DATA_W-1:1] != '0) begin
            report_mismatch("zero fill", int'(m_tdata[OUT_DATA_W-1:1]), 0);
          end
          if (expected_hits[0]) hits_seen++;
          void'(expected_hits.pop_front());
        end
        if (results_seen % 40 == 0) begin
          sink_mode = $urandom_range(0, 3);
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else if (items_total - items_accepted > 60 && sink_mode != 0 &&
                   $urandom_range(0, 15) < sink_mode) begin
        sink_stall = $urandom_range(1, 19) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, expected_hits.size());
      $display("FAIL neighborhood_pattern_match_table");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [NEIGH_W-1:0]    known_value [$];
    logic [NEIGH_W-1:0]    known_care [$];
    logic [TASK_FLD_W-1:0] known_tasks [$];
    logic [NEIGH_W-1:0]    value;
    logic [NEIGH_W-1:0]    care;
    logic [TASK_FLD_W-1:0] tasks;
    logic [TASK_IDX_W-1:0] tidx;
    int pick;
    int n_loads;
    int n_queries;

    for (int n = 0; n < DEPTH; n++) task_marks[n] = '0;

    // Freshly cleared table answers miss everywhere.
    add_query(9'h000, 2'd0);
    add_query(9'h1FF, 2'd3);
    // Fully cared pattern for the first task only.
    add_load(9'h1FF, 9'h1FF, 4'b0001);
    add_query(9'h1FF, 2'd0);
    add_query(9'h1FF, 2'd1);
    add_query(9'h1FE, 2'd0);
    // A pattern with an empty task set leaves the table unchanged.
    add_load(9'h000, 9'h000, 4'b0000);
    add_query(9'h000, 2'd2);
    // A pattern that cares about nothing covers every neighborhood;
    // its value bits all fall under don't care.
    add_load(9'h0AA, 9'h000, 4'b1000);
    add_query(9'h000, 2'd3);
    add_query(9'h155, 2'd3);
    // Only bit 0 is cared; the other value bits are ignored.
    add_load(9'h1FF, 9'h001, 4'b0110);
    add_query(9'h001, 2'd1);
    add_query(9'h002, 2'd1);
    add_query(9'h003, 2'd2);
    // Overlapping patterns combine their task marks.
    add_load(9'h000, 9'h1FE, 4'b0001);
    add_query(9'h001, 2'd0);
    add_query(9'h001, 2'd1);
    add_query(9'h000, 2'd0);
    add_query(9'h100, 2'd0);

    // Random part: mostly a load followed by queries aimed at what it covers,
    // mixed with stray queries against the whole table.
    while (pending_items.size() < 620) begin
      if (known_value.size() == 0 || $urandom_range(0, 7) == 0) begin
        value = NEIGH_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
          care = NEIGH_W'($urandom);
        end else begin
          care = '1;
          repeat ($urandom_range(0, 3)) care[$urandom_range(0, NEIGH_W - 1)] = 1'b0;
        end
        tasks = TASK_FLD_W'($urandom);
        add_load(value, care, tasks);
        known_value.push_back(value);
        known_care.push_back(care);
        known_tasks.push_back(tasks);
      end
      repeat ($urandom_range(4, 12)) begin
        if ($urandom_range(0, 2) != 0) begin
          pick  = $urandom_range(0, known_value.size() - 1);
          care  = known_care[pick];
          value = (known_value[pick] & care) | (NEIGH_W'($urandom) & ~care);
          tidx  = TASK_IDX_W'($urandom);
          // Aim at one of the pattern's tasks most of the time.
          if (known_tasks[pick] != '0 && $urandom_range(0, 3) != 0) begin
            while (!known_tasks[pick][tidx]) tidx = TASK_IDX_W'($urandom);
          end
          add_query(value, tidx);
        end else begin
          add_query(NEIGH_W'($urandom), TASK_IDX_W'($urandom));
        end
      end
    end

    n_loads   = 0;
    n_queries = 0;
    foreach (pending_items[i]) begin
      if (pending_items[i].cmd == CMD_LOAD) n_loads++;
      else n_queries++;
    end
    items_total = pending_items.size();
    cycle_limit = 4 * (DEPTH + n_loads * (DEPTH + 2 + 40) + n_queries * 42) + 4000;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted < items_total || expected_hits.size() > 0) @(posedge clk);
    // A trailing load sweep may still be running; catch any stray result.
    repeat (DEPTH + 100) @(posedge clk);

    $display("Streamed %0d loads and %0d queries; %0d results checked, %0d of them hits.",
             loads_applied, queries_sent, results_seen, hits_seen);
    if (error_count == 0 && expected_hits.size() == 0) begin
      $display("PASS neighborhood_pattern_match_table");
    end else begin
      $display("%0d mismatches, %0d results never arrived.", error_count,
               expected_hits.size());
      $display("FAIL neighborhood_pattern_match_table");
    end
    $finish;
  end

endmodule

[files.f]
rtl/npmt_pkg.sv
rtl/npmt_bitmap.sv
rtl/neighborhood_pattern_match_table.sv
bench/tb.sv
